// ----- rtl/dcpm_pkg.sv -----
// Shared types and constants for the dual-capture phase meter.
// No dependencies; used by every module under rtl.
package dcpm_pkg;

  typedef enum logic [1:0] {
    FUNC_OVF = 2'd0,
    FUNC_CH1 = 2'd1,
    FUNC_CH2 = 2'd2
  } func_e;

  typedef struct packed {
    logic ovf;
    logic cap;
  } chan_evt_t;

  typedef struct packed {
    logic done;
    logic falling;
    logic clr;
  } chan_stat_t;

  localparam int unsigned OUT_W       = 22;
  localparam int unsigned SCALE_W     = 32;
  localparam int unsigned PHASE_SHIFT = 24;

  localparam logic [SCALE_W-1:0] DEGREE_SCALE_RST = 32'd9203501;
  localparam logic               REG_DEGREE_SCALE = 1'b0;

endpackage

// ----- rtl/dcpm_chan.sv -----
// Edge machine for one capture channel: arm, overflow count, capture, clear.
// Depends on dcpm_pkg.
module dcpm_chan #(
  parameter int unsigned COUNTER_BITS  = 16,
  parameter int unsigned OVERFLOW_BITS = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  dcpm_pkg::chan_evt_t                  evt_i,
  input  logic [COUNTER_BITS-1:0]              value_i,
  input  logic                                 clear_i,
  output dcpm_pkg::chan_stat_t                 stat_o,
  output logic [OVERFLOW_BITS+COUNTER_BITS-1:0] time_o
);

  logic                     armed_q, armed_d, nxt_armed;
  logic                     done_q, done_d, nxt_done;
  logic                     falling_q, falling_d, nxt_falling;
  logic [OVERFLOW_BITS-1:0] ovf_q, ovf_d, nxt_ovf;
  logic [COUNTER_BITS-1:0]  cap_q, cap_d, nxt_cap;
  logic                     clr;

  always_comb begin
    nxt_armed   = armed_q;
    nxt_done    = done_q;
    nxt_falling = falling_q;
    nxt_ovf     = ovf_q;
    nxt_cap     = cap_q;
    clr         = 1'b0;
    if (evt_i.ovf && armed_q && !done_q) begin
      if (&ovf_q) begin
        nxt_done = 1'b1;
        nxt_cap  = '1;
      end else begin
        nxt_ovf = ovf_q + OVERFLOW_BITS'(1);
      end
    end
    if (evt_i.cap && !done_q) begin
      if (armed_q) begin
        nxt_done    = 1'b1;
        nxt_cap     = value_i;
        nxt_falling = 1'b0;
      end else begin
        nxt_armed   = 1'b1;
        nxt_ovf     = '0;
        nxt_falling = 1'b1;
        clr         = 1'b1;
      end
    end
  end

  always_comb begin
    armed_d   = armed_q;
    done_d    = done_q;
    falling_d = falling_q;
    ovf_d     = ovf_q;
    cap_d     = cap_q;
    if (step_i) begin
      falling_d = nxt_falling;
      cap_d     = nxt_cap;
      if (clear_i) begin
        armed_d = 1'b0;
        done_d  = 1'b0;
        ovf_d   = '0;
      end else begin
        armed_d = nxt_armed;
        done_d  = nxt_done;
        ovf_d   = nxt_ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      done_q    <= 1'b0;
      falling_q <= 1'b0;
      ovf_q     <= '0;
      cap_q     <= '0;
    end else begin
      armed_q   <= armed_d;
      done_q    <= done_d;
      falling_q <= falling_d;
      ovf_q     <= ovf_d;
      cap_q     <= cap_d;
    end
  end

  assign stat_o.done    = nxt_done;
  assign stat_o.falling = nxt_falling;
  assign stat_o.clr     = clr;
  assign time_o         = {nxt_ovf, nxt_cap};

endmodule

// ----- rtl/dcpm_phase.sv -----
// Phase scaling: tick difference times degree scale, shifted to Q8, saturated.
// Depends on dcpm_pkg.
module dcpm_phase (
  input  logic [dcpm_pkg::OUT_W-1:0]   diff_i,
  input  logic [dcpm_pkg::SCALE_W-1:0] scale_i,
  output logic [dcpm_pkg::OUT_W-1:0]   phase_o
);

  localparam int unsigned ProdW  = dcpm_pkg::OUT_W + dcpm_pkg::SCALE_W;
  localparam int unsigned ShiftW = ProdW - dcpm_pkg::PHASE_SHIFT;

  logic [ProdW-1:0]  prod;
  logic [ShiftW-1:0] shifted;

  assign prod    = ProdW'(diff_i) * ProdW'(scale_i);
  assign shifted = prod[ProdW-1:dcpm_pkg::PHASE_SHIFT];
  assign phase_o = (|shifted[ShiftW-1:dcpm_pkg::OUT_W]) ? '1
                                                       : shifted[dcpm_pkg::OUT_W-1:0];

endmodule

// ----- rtl/dual_capture_phase_meter.sv -----
// Dual-capture phase meter: takes one timer event item per cycle unless the output
// stalls, and returns one result item per event through its stages (input register,
// channel update, phase multiply into the output register). The 22x32 multiply in
// the last stage sets the clock path; each stage holds or drains on its own.
module dual_capture_phase_meter #(
  parameter int unsigned COUNTER_BITS  = 16,
  parameter int unsigned OVERFLOW_BITS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [COUNTER_BITS-1:0]       capture_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          clear_counter_o,
  output logic                          ch1_edge_falling_o,
  output logic                          ch2_edge_falling_o,
  output logic                          phase_valid_o,
  output logic [dcpm_pkg::OUT_W-1:0]    tick_difference_o,
  output logic [dcpm_pkg::OUT_W-1:0]    phase_q8_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [2:0]                    paddr_i,
  input  logic [dcpm_pkg::SCALE_W-1:0]  pwdata_i,
  output logic [dcpm_pkg::SCALE_W-1:0]  prdata_o,
  output logic                          pready_o
);

  localparam int unsigned TimeW = OVERFLOW_BITS + COUNTER_BITS;
  localparam int unsigned ExtW  = TimeW + dcpm_pkg::OUT_W;

  logic [dcpm_pkg::SCALE_W-1:0] scale_q, scale_d;
  logic                         cfg_wr;

  logic                         v1_q, v2_q, v3_q;
  logic                         en1, en2, en3, step;
  logic [1:0]                   func_q;
  logic [COUNTER_BITS-1:0]      value_q;

  dcpm_pkg::chan_evt_t          evt1, evt2;
  dcpm_pkg::chan_stat_t         stat1, stat2;
  logic [TimeW-1:0]             time1, time2;
  logic                         both_done;
  logic [ExtW-1:0]              ext1, ext2, ext_diff;
  logic [dcpm_pkg::OUT_W-1:0]   diff;

  logic                         clr2_q, f1_q, f2_q, pv2_q;
  logic [dcpm_pkg::OUT_W-1:0]   diff2_q;
  logic [dcpm_pkg::OUT_W-1:0]   phase;

  logic                         clr3_q, f13_q, f23_q, pv3_q;
  logic [dcpm_pkg::OUT_W-1:0]   diff3_q, phase3_q;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o &&
                    (paddr_i[2] == dcpm_pkg::REG_DEGREE_SCALE);
  assign scale_d  = cfg_wr ? pwdata_i : scale_q;
  assign prdata_o = (paddr_i[2] == dcpm_pkg::REG_DEGREE_SCALE) ? scale_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= dcpm_pkg::DEGREE_SCALE_RST;
    end else begin
      scale_q <= scale_d;
    end
  end

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign step       = v1_q && en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && en1) begin
      func_q  <= func_i;
      value_q <= capture_value_i;
    end
  end

  always_comb begin
    evt1 = '0;
    evt2 = '0;
    case (dcpm_pkg::func_e'(func_q))
      dcpm_pkg::FUNC_OVF: begin
        evt1.ovf = 1'b1;
        evt2.ovf = 1'b1;
      end
      dcpm_pkg::FUNC_CH1: evt1.cap = 1'b1;
      dcpm_pkg::FUNC_CH2: evt2.cap = 1'b1;
      default: ;
    endcase
  end

  dcpm_chan #(
    .COUNTER_BITS (COUNTER_BITS),
    .OVERFLOW_BITS(OVERFLOW_BITS)
  ) u_ch1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .evt_i  (evt1),
    .value_i(value_q),
    .clear_i(both_done),
    .stat_o (stat1),
    .time_o (time1)
  );

  dcpm_chan #(
    .COUNTER_BITS (COUNTER_BITS),
    .OVERFLOW_BITS(OVERFLOW_BITS)
  ) u_ch2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .evt_i  (evt2),
    .value_i(value_q),
    .clear_i(both_done),
    .stat_o (stat2),
    .time_o (time2)
  );

  assign both_done = stat1.done && stat2.done;
  assign ext1      = ExtW'(time1);
  assign ext2      = ExtW'(time2);
  assign ext_diff  = (ext1 > ext2) ? (ext1 - ext2) : (ext2 - ext1);
  assign diff      = both_done ? ext_diff[dcpm_pkg::OUT_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (step) begin
      clr2_q  <= stat1.clr || stat2.clr;
      f1_q    <= stat1.falling;
      f2_q    <= stat2.falling;
      pv2_q   <= both_done;
      diff2_q <= diff;
    end
  end

  dcpm_phase u_phase (
    .diff_i (diff2_q),
    .scale_i(scale_q),
    .phase_o(phase)
  );

  always_ff @(posedge clk_i) begin
    if (v2_q && en3) begin
      clr3_q   <= clr2_q;
      f13_q    <= f1_q;
      f23_q    <= f2_q;
      pv3_q    <= pv2_q;
      diff3_q  <= diff2_q;
      phase3_q <= phase;
    end
  end

  assign out_valid_o        = v3_q;
  assign clear_counter_o    = clr3_q;
  assign ch1_edge_falling_o = f13_q;
  assign ch2_edge_falling_o = f23_q;
  assign phase_valid_o      = pv3_q;
  assign tick_difference_o  = diff3_q;
  assign phase_q8_o         = phase3_q;

  a_idle_output_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register empty");

  a_no_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !phase_valid_o) |-> (tick_difference_o == '0 && phase_q8_o == '0))
    else $error("nonzero measurement without phase_valid");

  a_arm_not_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(clear_counter_o && phase_valid_o))
    else $error("arming event reported a completed measurement");

endmodule
